/* hdl/tren_pkg.sv */
`default_nettype none
package tren_pkg;

	// sizing of the text pool and the entity lookahead
	localparam int POOL_BYTES    = 4096;
	localparam int ENTITY_WINDOW = 12;
	localparam int PF_W          = $clog2(POOL_BYTES + 1);
	localparam int LA_W          = $clog2(ENTITY_WINDOW + 1);
	localparam int RI_W          = $clog2(ENTITY_WINDOW);
	localparam int RING          = 1 << RI_W;
	localparam int NUM_ENT       = 5;

	localparam logic [20:0] CP_MAX = 21'h10FFFF;

	// characters the scanner looks for
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       first_of_run;
		logic       last_of_run;
	} item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic [11:0] write_addr;
		logic        overflow;
		logic        run_done;
		logic [12:0] run_offset;
		logic [12:0] run_length;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROC,
		ST_WORK
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic proc;
		logic settle;
		logic enc;
		logic replay;
		logic fin;
		logic flush;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic can_emit;
		logic out_free;
		logic last;
		logic trig;
		logic settle_pend;
		logic enc_pend;
		logic repl_pend;
		logic ent_pend;
		logic ovf;
	} sts_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) ||
			(c == 8'h0C) || (c == 8'h0B);
	endfunction

	function automatic logic [2:0] ent_len(input int e);
		logic [2:0] r;
		case (e)
			0: r = 3'd3;
			1: r = 3'd2;
			2: r = 3'd2;
			3: r = 3'd4;
			default: r = 3'd4;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] ent_char(input int e);
		logic [7:0] r;
		case (e)
			0: r = 8'h26;
			1: r = 8'h3C;
			2: r = 8'h3E;
			3: r = 8'h22;
			default: r = 8'h27;
		endcase
		return r;
	endfunction

	// name letters: amp lt gt quot apos
	function automatic logic [7:0] ent_name_char(input int e, input logic [1:0] i);
		logic [7:0] r;
		case (e)
			0: case (i)
				2'd0: r = 8'h61;
				2'd1: r = 8'h6D;
				default: r = 8'h70;
			endcase
			1: r = (i == 2'd0) ? 8'h6C : 8'h74;
			2: r = (i == 2'd0) ? 8'h67 : 8'h74;
			3: case (i)
				2'd0: r = 8'h71;
				2'd1: r = 8'h75;
				2'd2: r = 8'h6F;
				default: r = 8'h74;
			endcase
			default: case (i)
				2'd0: r = 8'h61;
				2'd1: r = 8'h70;
				2'd2: r = 8'h6F;
				default: r = 8'h73;
			endcase
		endcase
		return r;
	endfunction

	// match step for a byte landing at position p (p >= 2) of the entity
	function automatic logic ent_step(input int e, input logic [LA_W-1:0] p,
			input logic [7:0] b);
		logic [LA_W-1:0] len;
		logic            r;
		len = LA_W'(ent_len(e));
		if (p <= len)
			r = (b == ent_name_char(e, 2'(p - LA_W'(1))));
		else if (p == len + LA_W'(1))
			r = (b == CH_SEMI);
		else
			r = 1'b0;
		return r;
	endfunction

	// index of the final UTF-8 byte (length minus one)
	function automatic logic [1:0] utf8_last(input logic [20:0] cp);
		logic [1:0] r;
		if (cp < 21'h80)
			r = 2'd0;
		else if (cp < 21'h800)
			r = 2'd1;
		else if (cp < 21'h10000)
			r = 2'd2;
		else
			r = 2'd3;
		return r;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] k);
		logic [1:0] n;
		logic [1:0] sh;
		logic [5:0] six;
		logic [7:0] r;
		n  = utf8_last(cp);
		sh = n - k;
		case (sh)
			2'd0: six = cp[5:0];
			2'd1: six = cp[11:6];
			2'd2: six = cp[17:12];
			default: six = {3'b000, cp[20:18]};
		endcase
		if (k != 2'd0)
			r = {2'b10, six};
		else begin
			case (n)
				2'd0: r = cp[7:0];
				2'd1: r = {3'b110, cp[10:6]};
				2'd2: r = {4'b1110, cp[15:12]};
				default: r = {5'b11110, cp[20:18]};
			endcase
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* hdl/text_run_entity_normalizer_core.sv */
// A plain byte is worked in the cycle after its request is taken; its result passes through the
// pending result slot and then the output slot, and the closing result of a run goes to the output slot.
// A request is taken only in the idle state, so each byte is worked before the next is taken, and the
// last byte of a run also closes the run. Entity work settles the entity, encodes each UTF-8 byte or
// replays each byte from the lookahead ring, then leaves the work state. Output stalls hold all of it.
// Reset: clears the pool fill, run and result state; lookahead ring contents stay unset.
`default_nettype none
module text_run_entity_normalizer_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  tren_pkg::item_t item,
	output logic            res_valid,
	input  logic            res_stall,
	output tren_pkg::res_t  res
);

	tren_pkg::cmd_t   cmd;
	tren_pkg::sts_t   sts;
	tren_pkg::state_t st;

	tren_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd),
		.st         (st)
	);

	tren_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res),
		.res_valid (res_valid),
		.res_stall (res_stall)
	);

`ifndef SYNTH
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		st == tren_pkg::ST_IDLE |-> !sts.repl_pend && !sts.settle_pend && !sts.enc_pend)
		else $error("idle with entity work outstanding");

	a_ovf_clear: assert property (@(posedge clk) disable iff (!arst_n)
		sts.ovf |-> !sts.ent_pend && !sts.repl_pend)
		else $error("lookahead kept after pool overflow");

	a_take_proc: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> st == tren_pkg::ST_PROC)
		else $error("taken request not processed");
`endif

endmodule
`default_nettype wire

/* hdl/tren_ctrl.sv */
`default_nettype none
module tren_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  tren_pkg::sts_t    sts,
	output tren_pkg::cmd_t    cmd,
	output tren_pkg::state_t st
);

	tren_pkg::state_t st_q;
	tren_pkg::state_t nxt;

	assign st = st_q;

	// take a request only when idle and the result slot can move on
	assign item_stall = !((st_q == tren_pkg::ST_IDLE) && sts.can_emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= tren_pkg::ST_IDLE;
		end else begin
			st_q <= nxt;
		end
	end

	// pick one action per cycle
	always_comb begin
		nxt = st_q;
		cmd = '0;
		unique case (st_q)
			tren_pkg::ST_IDLE: begin
				cmd.flush = 1'b1;
				if (item_valid && sts.can_emit) begin
					cmd.load = 1'b1;
					nxt      = tren_pkg::ST_PROC;
				end
			end
			tren_pkg::ST_PROC: begin
				if (sts.can_emit) begin
					cmd.proc = 1'b1;
					nxt      = (sts.last || sts.trig) ? tren_pkg::ST_WORK : tren_pkg::ST_IDLE;
				end
			end
			tren_pkg::ST_WORK: begin
				if (sts.settle_pend) begin
					cmd.settle = sts.can_emit;
				end else if (sts.enc_pend) begin
					cmd.enc = sts.can_emit;
				end else if (sts.repl_pend) begin
					cmd.replay = sts.can_emit;
				end else if (sts.ent_pend && sts.last) begin
					cmd.settle = sts.can_emit;
				end else if (sts.last) begin
					if (sts.out_free) begin
						cmd.fin = 1'b1;
						nxt     = tren_pkg::ST_IDLE;
					end
				end else begin
					nxt = tren_pkg::ST_IDLE;
				end
			end
			default: nxt = tren_pkg::ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

/* hdl/tren_dp.sv */
`default_nettype none
module tren_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  tren_pkg::item_t item,
	input  tren_pkg::cmd_t  cmd,
	output tren_pkg::sts_t  sts,
	output tren_pkg::res_t  res,
	output logic            res_valid,
	input  logic            res_stall
);

	localparam int LW = tren_pkg::LA_W;
	localparam int RW = tren_pkg::RI_W;
	localparam int PW = tren_pkg::PF_W;

	// request and lookahead ring
	tren_pkg::item_t in_q;
	logic [7:0]      buf_q [tren_pkg::RING];
	logic [RW-1:0]   hd_q;
	logic [LW-1:0]   ent_q;
	logic [LW-1:0]   rep_q;

	// entity tracker
	logic                         is_num_q, is_hex_q, bad_q, dig_q, semi_q;
	logic [31:0]                  cp_q;
	logic [tren_pkg::NUM_ENT-1:0] nm_q;

	// encoder
	logic [20:0] dec_q;
	logic [1:0]  enc_k_q, enc_n_q;
	logic        enc_pend_q, settle_q;

	// run and pool bookkeeping
	logic          after_sp_q, ovf_q;
	logic [PW-1:0] pf_q, rs_q;

	// result slots
	tren_pkg::res_t pend_q, out_q;
	logic           pend_v_q, out_v_q;

	logic           out_free, can_emit;
	logic [RW-1:0]  rd_idx;
	logic [7:0]     sb;
	logic           do_scan, trig_c;
	logic           st_req, ws, kept, full, emit, ovf_set;
	logic [7:0]     st_ch, ch_out;
	logic [3:0]     dval;
	logic           dig_ok;
	logic [31:0]    cp_nx;
	logic           dec_ok;
	logic [20:0]    dec_val, nm_val;
	logic [PW-1:0]  len_nx, len_now;
	tren_pkg::res_t new_res, fin_res;
	logic           load_out;

	assign out_free = !out_v_q || !res_stall;
	assign can_emit = !pend_v_q || out_free;

	// scanned byte: replay head or the held request
	assign rd_idx  = hd_q + RW'(ent_q);
	assign sb      = cmd.replay ? buf_q[rd_idx] : in_q.in_byte;
	assign do_scan = (cmd.proc || cmd.replay) && !ovf_q;
	assign trig_c  = (ent_q >= LW'(tren_pkg::ENTITY_WINDOW - 1)) || (sb == tren_pkg::CH_SEMI);

	// digit value for the numeric reference
	always_comb begin
		dval   = 4'd0;
		dig_ok = 1'b0;
		if (sb >= 8'h30 && sb <= 8'h39) begin
			dval   = 4'(sb - 8'h30);
			dig_ok = 1'b1;
		end else if (is_hex_q && sb >= 8'h61 && sb <= 8'h66) begin
			dval   = 4'(sb - 8'h57);
			dig_ok = 1'b1;
		end else if (is_hex_q && sb >= 8'h41 && sb <= 8'h46) begin
			dval   = 4'(sb - 8'h37);
			dig_ok = 1'b1;
		end
	end

	assign cp_nx = is_hex_q ? ({cp_q[27:0], 4'b0000} + 32'(dval)) :
		({cp_q[28:0], 3'b000} + {cp_q[30:0], 1'b0} + 32'(dval));

	// settle outcome
	always_comb begin
		nm_val = '0;
		for (int e = 0; e < tren_pkg::NUM_ENT; e++) begin
			if (nm_q[e])
				nm_val = nm_val | 21'(tren_pkg::ent_char(e));
		end
	end

	assign dec_ok  = semi_q && (is_num_q ? (!bad_q && dig_q) : (|nm_q));
	assign dec_val = !is_num_q ? nm_val :
		((cp_q > 32'(tren_pkg::CP_MAX)) ? tren_pkg::CP_MAX : cp_q[20:0]);

	// select what goes through whitespace collapse
	always_comb begin
		st_req = 1'b0;
		st_ch  = sb;
		if (do_scan && ent_q == '0 && sb != tren_pkg::CH_AMP) begin
			st_req = 1'b1;
		end else if (cmd.settle && !dec_ok) begin
			st_req = 1'b1;
			st_ch  = tren_pkg::CH_AMP;
		end else if (cmd.enc) begin
			st_req = 1'b1;
			st_ch  = tren_pkg::utf8_byte(dec_q, enc_k_q);
		end
	end

	assign ws      = tren_pkg::is_ws(st_ch);
	assign kept    = st_req && !ovf_q && !(ws && after_sp_q);
	assign full    = pf_q >= PW'(tren_pkg::POOL_BYTES);
	assign emit    = kept && !full;
	assign ovf_set = kept && full;
	assign ch_out  = ws ? tren_pkg::CH_SPACE : st_ch;

	assign len_nx  = pf_q + PW'(1) - rs_q;
	assign len_now = pf_q - rs_q;

	always_comb begin
		new_res.out_byte   = ch_out;
		new_res.byte_valid = 1'b1;
		new_res.write_addr = 12'(pf_q);
		new_res.overflow   = ovf_q;
		new_res.run_done   = 1'b0;
		new_res.run_offset = 13'(rs_q);
		new_res.run_length = 13'(len_nx);
	end

	// final result of a run
	always_comb begin
		if (pend_v_q) begin
			fin_res = pend_q;
		end else begin
			fin_res.out_byte   = 8'h00;
			fin_res.byte_valid = 1'b0;
			fin_res.write_addr = 12'(pf_q);
			fin_res.run_offset = 13'(rs_q);
		end
		fin_res.overflow   = ovf_q;
		fin_res.run_done   = 1'b1;
		fin_res.run_length = 13'(len_now);
		if (!pend_v_q) begin
			fin_res.overflow = ovf_q;
		end
	end

	assign load_out = cmd.fin || (emit && pend_v_q) || (cmd.flush && pend_v_q && out_free);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hd_q       <= '0;
			ent_q      <= '0;
			rep_q      <= '0;
			settle_q   <= 1'b0;
			enc_pend_q <= 1'b0;
			enc_k_q    <= '0;
			enc_n_q    <= '0;
			after_sp_q <= 1'b1;
			ovf_q      <= 1'b0;
			pf_q       <= '0;
			rs_q       <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			// start a new run on request
			if (cmd.load && item.first_of_run) begin
				rs_q       <= pf_q;
				after_sp_q <= 1'b1;
				ovf_q      <= 1'b0;
				ent_q      <= '0;
			end
			// grow the entity or drop the replay head
			if (do_scan) begin
				if (ent_q != '0) begin
					ent_q <= ent_q + LW'(1);
					if (cmd.replay)
						rep_q <= rep_q - LW'(1);
					if (trig_c)
						settle_q <= 1'b1;
				end else if (sb == tren_pkg::CH_AMP) begin
					ent_q <= LW'(1);
					if (cmd.replay)
						rep_q <= rep_q - LW'(1);
				end else if (cmd.replay) begin
					hd_q  <= hd_q + RW'(1);
					rep_q <= rep_q - LW'(1);
				end
			end
			// decode or fall back to a literal ampersand and rescan
			if (cmd.settle) begin
				settle_q <= 1'b0;
				ent_q    <= '0;
				if (dec_ok) begin
					hd_q       <= hd_q + RW'(ent_q);
					enc_pend_q <= 1'b1;
					enc_k_q    <= '0;
					enc_n_q    <= tren_pkg::utf8_last(dec_val);
				end else begin
					hd_q  <= hd_q + RW'(1);
					rep_q <= rep_q + ent_q - LW'(1);
				end
			end
			// advance the encoder
			if (cmd.enc) begin
				enc_k_q <= enc_k_q + 2'd1;
				if (enc_k_q == enc_n_q)
					enc_pend_q <= 1'b0;
			end
			if (st_req && !ovf_q)
				after_sp_q <= ws;
			if (emit)
				pf_q <= pf_q + PW'(1);
			// pool full: drop the rest of the run
			if (ovf_set) begin
				ovf_q      <= 1'b1;
				ent_q      <= '0;
				rep_q      <= '0;
				settle_q   <= 1'b0;
				enc_pend_q <= 1'b0;
			end
			if (cmd.fin) begin
				rs_q       <= pf_q;
				after_sp_q <= 1'b1;
				ovf_q      <= 1'b0;
				ent_q      <= '0;
			end
			// result slots
			if (cmd.fin)
				pend_v_q <= 1'b0;
			else if (emit)
				pend_v_q <= 1'b1;
			else if (cmd.flush && out_free)
				pend_v_q <= 1'b0;
			if (load_out)
				out_v_q <= 1'b1;
			else if (!res_stall)
				out_v_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load)
			in_q <= item;
		if (cmd.proc && !ovf_q && (ent_q != '0 || sb == tren_pkg::CH_AMP))
			buf_q[rd_idx] <= sb;
		if (do_scan && ent_q == '0 && sb == tren_pkg::CH_AMP) begin
			semi_q   <= 1'b0;
			is_num_q <= 1'b0;
			nm_q     <= '0;
		end
		if (do_scan && ent_q != '0) begin
			semi_q <= (sb == tren_pkg::CH_SEMI);
			if (ent_q == LW'(1)) begin
				is_num_q <= (sb == tren_pkg::CH_HASH);
				is_hex_q <= 1'b0;
				bad_q    <= 1'b0;
				dig_q    <= 1'b0;
				cp_q     <= '0;
				for (int e = 0; e < tren_pkg::NUM_ENT; e++)
					nm_q[e] <= (sb == tren_pkg::ent_name_char(e, 2'd0));
			end else begin
				if (ent_q == LW'(2) && (sb == tren_pkg::CH_LX || sb == tren_pkg::CH_UX)) begin
					is_hex_q <= 1'b1;
				end else if (sb != tren_pkg::CH_SEMI) begin
					if (dig_ok) begin
						cp_q  <= cp_nx;
						dig_q <= 1'b1;
					end else begin
						bad_q <= 1'b1;
					end
				end
				for (int e = 0; e < tren_pkg::NUM_ENT; e++)
					nm_q[e] <= nm_q[e] && tren_pkg::ent_step(e, ent_q, sb);
			end
		end
		if (cmd.settle && dec_ok)
			dec_q <= dec_val;
		if (emit)
			pend_q <= new_res;
		if (load_out)
			out_q <= cmd.fin ? fin_res : pend_q;
	end

	assign res       = out_q;
	assign res_valid = out_v_q;

	always_comb begin
		sts.can_emit    = can_emit;
		sts.out_free    = out_free;
		sts.last        = in_q.last_of_run;
		sts.trig        = !ovf_q && (ent_q != '0) &&
			((ent_q >= LW'(tren_pkg::ENTITY_WINDOW - 1)) || (in_q.in_byte == tren_pkg::CH_SEMI));
		sts.settle_pend = settle_q;
		sts.enc_pend    = enc_pend_q;
		sts.repl_pend   = rep_q != '0;
		sts.ent_pend    = ent_q != '0;
		sts.ovf         = ovf_q;
	end

endmodule
`default_nettype wire
